>>> rtl/tpsc_pkg.sv
// Package for the takeover packet steering classifier.
// Types, codes and field widths shared by the range cells and the top level.
// No dependencies.
package tpsc_pkg;

  localparam int unsigned MAC_W      = 48;
  localparam int unsigned PORT_W     = 16;
  localparam int unsigned LEN_W      = 16;
  localparam int unsigned PROTO_W    = 8;
  localparam int unsigned IDX_W      = 3;
  localparam int unsigned CMP_W      = 8;   // width used to compare cell positions
  localparam int unsigned IN_DATA_W  = 208;
  localparam int unsigned OUT_DATA_W = 72;
  localparam int unsigned APB_DATA_W = 64;
  localparam int unsigned APB_ADDR_W = 6;

  localparam logic [1:0]         MODE_STEER = 2'd2;
  localparam logic [PROTO_W-1:0] PROTO_TCP  = 8'd6;
  localparam logic [PROTO_W-1:0] PROTO_UDP  = 8'd17;

  typedef enum logic [1:0] {
    ACT_DROP    = 2'd0,
    ACT_ATTACK  = 2'd1,
    ACT_FWD     = 2'd2,
    ACT_FWD_RST = 2'd3
  } action_e;

  typedef enum logic {
    OP_CLASSIFY = 1'b0,
    OP_WRITE    = 1'b1
  } opcode_e;

  typedef enum logic [2:0] {
    REG_MODE         = 3'd0,
    REG_SNIFF_MAC    = 3'd1,
    REG_OWN_MAC      = 3'd2,
    REG_TAKEOVER_MAC = 3'd3,
    REG_RANGE_COUNT  = 3'd4
  } reg_e;

  // Token that walks the cell chain: ports under test and hit flags so far.
  typedef struct packed {
    logic              valid;
    logic [PORT_W-1:0] sport;
    logic [PORT_W-1:0] dport;
    logic              hit_s;
    logic              hit_d;
  } tok_t;

endpackage

>>> rtl/tpsc_cell.sv
// One port range cell of the classifier chain.
// Holds one range entry and tests the passing token against it. Uses tpsc_pkg.
module tpsc_cell
  import tpsc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_en_i,
  input  logic [PORT_W-1:0] wr_begin_i,
  input  logic [PORT_W-1:0] wr_end_i,
  input  logic              active_i,
  input  tok_t              tok_i,
  output tok_t              tok_o
);

  logic [PORT_W-1:0] begin_q;
  logic [PORT_W-1:0] end_q;
  tok_t              tok_d;
  tok_t              tok_q;

  // entry contents are undefined until written
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      begin_q <= wr_begin_i;
      end_q   <= wr_end_i;
    end
  end

  // begin > end matches nothing by construction
  always_comb begin
    tok_d       = tok_i;
    tok_d.hit_s = tok_i.hit_s | (active_i && tok_i.sport >= begin_q && tok_i.sport <= end_q);
    tok_d.hit_d = tok_i.hit_d | (active_i && tok_i.dport >= begin_q && tok_i.dport <= end_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

>>> rtl/takeover_packet_steering_classifier.sv
// Takeover packet steering classifier, top level. Uses tpsc_pkg and tpsc_cell.
// Path of a classify transfer: one register per range cell, then the decision register
// (hit flags and done), then the output register, which loads once the output is free.
// Input is held off while a classify is in flight until its results are all loaded, two
// for a swapped reset; a range write is taken whenever no classify is busy.
// Reset: async active low; config registers clear to 0, range entries are undefined.
module takeover_packet_steering_classifier
  import tpsc_pkg::*;
#(
  parameter int unsigned RANGES = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input stream
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // tdata, low bit up: entry_index[3], range_begin[16], range_end[16], dest_mac[48],
  // source_mac[48], ip_protocol[8], source_port[16], dest_port[16], reset_flag[1],
  // ip_total_len[16], captured_len[16], zero pad[4]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // tuser: opcode[1]
  input  logic                  s_axis_tuser_i,
  // result stream
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // tdata, low bit up: action[2], forward_src_mac[48], out_len[16], zero pad[6]
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  output logic                  m_axis_tlast_o,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  // ---------------------------------------------------------------- config
  logic [1:0]       mode_q;
  logic [MAC_W-1:0] sniff_mac_q;
  logic [MAC_W-1:0] own_mac_q;
  logic [MAC_W-1:0] takeover_mac_q;
  logic [3:0]       range_count_q;
  logic             cfg_we;
  reg_e             cfg_sel;

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite & pready;
  assign cfg_sel = reg_e'(paddr[5:3]);   // 8-byte register slots

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q         <= '0;
      sniff_mac_q    <= '0;
      own_mac_q      <= '0;
      takeover_mac_q <= '0;
      range_count_q  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_sel)
        REG_MODE:         mode_q         <= pwdata[1:0];
        REG_SNIFF_MAC:    sniff_mac_q    <= pwdata[MAC_W-1:0];
        REG_OWN_MAC:      own_mac_q      <= pwdata[MAC_W-1:0];
        REG_TAKEOVER_MAC: takeover_mac_q <= pwdata[MAC_W-1:0];
        REG_RANGE_COUNT:  range_count_q  <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_MODE:         prdata = {62'd0, mode_q};
      REG_SNIFF_MAC:    prdata = {16'd0, sniff_mac_q};
      REG_OWN_MAC:      prdata = {16'd0, own_mac_q};
      REG_TAKEOVER_MAC: prdata = {16'd0, takeover_mac_q};
      REG_RANGE_COUNT:  prdata = {60'd0, range_count_q};
      default:          prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- input fields
  logic [IDX_W-1:0]   in_index;
  logic [PORT_W-1:0]  in_begin;
  logic [PORT_W-1:0]  in_end;
  logic [MAC_W-1:0]   in_dmac;
  logic [MAC_W-1:0]   in_smac;
  logic [PROTO_W-1:0] in_proto;
  logic [PORT_W-1:0]  in_sport;
  logic [PORT_W-1:0]  in_dport;
  logic               in_rst;
  logic [LEN_W-1:0]   in_iplen;
  logic [LEN_W-1:0]   in_caplen;

  assign in_index  = s_axis_tdata_i[2:0];
  assign in_begin  = s_axis_tdata_i[18:3];
  assign in_end    = s_axis_tdata_i[34:19];
  assign in_dmac   = s_axis_tdata_i[82:35];
  assign in_smac   = s_axis_tdata_i[130:83];
  assign in_proto  = s_axis_tdata_i[138:131];
  assign in_sport  = s_axis_tdata_i[154:139];
  assign in_dport  = s_axis_tdata_i[170:155];
  assign in_rst    = s_axis_tdata_i[171];
  assign in_iplen  = s_axis_tdata_i[187:172];
  assign in_caplen = s_axis_tdata_i[203:188];

  // ---------------------------------------------------------------- control
  logic busy_q;     // a classify is in the chain or its results are not all loaded
  logic done_q;     // token has left the chain, decision pending
  logic phase_q;    // first of two results loaded, second still to load
  logic out_valid_q;
  logic s_acc;
  logic acc_classify;
  logic acc_write;
  logic out_free;

  assign s_axis_tready_o = ~busy_q;
  assign s_acc        = s_axis_tvalid_i & ~busy_q;
  assign acc_classify = s_acc & (opcode_e'(s_axis_tuser_i) == OP_CLASSIFY);
  assign acc_write    = s_acc & (opcode_e'(s_axis_tuser_i) == OP_WRITE);
  assign out_free     = ~out_valid_q | m_axis_tready_i;

  // ---------------------------------------------------------------- cell chain
  tok_t chain [RANGES+1];

  always_comb begin
    chain[0]       = '0;
    chain[0].valid = acc_classify;
    chain[0].sport = in_sport;
    chain[0].dport = in_dport;
  end

  for (genvar g = 0; g < RANGES; g++) begin : g_cell
    logic cell_we;
    logic cell_active;

    // writes beyond RANGES hit no cell; a count above RANGES enables every cell
    assign cell_we     = acc_write && ({{(CMP_W-IDX_W){1'b0}}, in_index} == CMP_W'(g));
    assign cell_active = {{(CMP_W-4){1'b0}}, range_count_q} > CMP_W'(g);

    tpsc_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .wr_en_i    (cell_we),
      .wr_begin_i (in_begin),
      .wr_end_i   (in_end),
      .active_i   (cell_active),
      .tok_i      (chain[g]),
      .tok_o      (chain[g+1])
    );
  end

  // ---------------------------------------------------------------- packet hold
  logic [MAC_W-1:0]   pkt_dmac_q;
  logic [MAC_W-1:0]   pkt_smac_q;
  logic [PROTO_W-1:0] pkt_proto_q;
  logic               pkt_rst_q;
  logic [LEN_W-1:0]   pkt_len_q;
  logic               hit_s_q;
  logic               hit_d_q;

  always_ff @(posedge clk_i) begin
    if (acc_classify) begin
      pkt_dmac_q  <= in_dmac;
      pkt_smac_q  <= in_smac;
      pkt_proto_q <= in_proto;
      pkt_rst_q   <= in_rst;
      pkt_len_q   <= (in_iplen > in_caplen) ? in_caplen : in_iplen;
    end
    if (chain[RANGES].valid) begin
      hit_s_q <= chain[RANGES].hit_s;
      hit_d_q <= chain[RANGES].hit_d;
    end
  end

  // ---------------------------------------------------------------- decision
  action_e          dec_act;
  logic [MAC_W-1:0] dec_mac;
  logic             dec_two;
  logic             is_tcp;
  logic             is_tu;

  assign is_tcp = pkt_proto_q == PROTO_TCP;
  assign is_tu  = is_tcp | (pkt_proto_q == PROTO_UDP);

  always_comb begin
    dec_act = ACT_ATTACK;
    dec_mac = '0;
    dec_two = 1'b0;
    if (mode_q == MODE_STEER) begin
      if (pkt_dmac_q == sniff_mac_q) begin
        // sniff rules take priority when both MACs match
        if (is_tu && !hit_d_q) begin
          dec_act = ACT_DROP;
        end else if (is_tcp && pkt_rst_q) begin
          dec_act = ACT_FWD_RST;
          dec_mac = own_mac_q;
          dec_two = 1'b1;
        end
      end else if (pkt_dmac_q == own_mac_q) begin
        if (is_tu && hit_s_q) begin
          dec_act = ACT_DROP;
        end else begin
          dec_act = ACT_FWD;
          dec_mac = pkt_smac_q;
        end
      end
    end
  end

  // ---------------------------------------------------------------- output register
  action_e          out_act_q;
  logic [MAC_W-1:0] out_mac_q;
  logic [LEN_W-1:0] out_len_q;
  logic             out_last_q;
  logic             load;

  assign load = done_q & out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      done_q      <= 1'b0;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (acc_classify) begin
        busy_q <= 1'b1;
      end
      if (chain[RANGES].valid) begin
        done_q <= 1'b1;
      end
      if (load) begin
        out_valid_q <= 1'b1;
        if (!phase_q && dec_two) begin
          phase_q <= 1'b1;
        end else begin
          phase_q <= 1'b0;
          done_q  <= 1'b0;
          busy_q  <= 1'b0;
        end
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_len_q <= pkt_len_q;
      if (phase_q) begin
        // second transfer of a swapped reset: hand on to the attack path
        out_act_q  <= ACT_ATTACK;
        out_mac_q  <= '0;
        out_last_q <= 1'b1;
      end else begin
        out_act_q  <= dec_act;
        out_mac_q  <= dec_mac;
        out_last_q <= ~dec_two;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'd0, out_len_q, out_mac_q, out_act_q};
  assign m_axis_tlast_o  = out_last_q;

`ifndef SYNTHESIS
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> busy_q)
    else $error("decision pending while input side is open");

  a_phase_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> done_q)
    else $error("second result pending without a decision");

  a_rst_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_act_q == ACT_FWD_RST && m_axis_tready_i)
    |=> (out_valid_q && out_act_q == ACT_ATTACK && out_last_q))
    else $error("swapped reset not followed by its attack path transfer");
`endif

endmodule

>>> bench/tpsc_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the takeover packet steering classifier: mirrors the APB registers
// and the port range table, predicts steering verdicts per input transfer and checks
// the result stream and register reads against them. Depends on tpsc_pkg.
module tpsc_checker
  import tpsc_pkg::*;
#(
  parameter int unsigned RANGES = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [IN_DATA_W-1:0]  in_data_i,
  input  logic                  in_user_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [OUT_DATA_W-1:0] out_data_i,
  input  logic                  out_last_i,
  input  logic                  psel_i,
  input  logic                  penable_i,
  input  logic                  pwrite_i,
  input  logic [APB_ADDR_W-1:0] paddr_i,
  input  logic [APB_DATA_W-1:0] pwdata_i,
  input  logic [APB_DATA_W-1:0] prdata_i,
  input  logic                  pready_i,
  output int                    pending_o,
  output int                    fails_o
);

  // Input tdata layout, high bits first.
  typedef struct packed {
    logic [3:0]         pad;
    logic [LEN_W-1:0]   cap_len;
    logic [LEN_W-1:0]   ip_len;
    logic               rst_flag;
    logic [PORT_W-1:0]  dport;
    logic [PORT_W-1:0]  sport;
    logic [PROTO_W-1:0] proto;
    logic [MAC_W-1:0]   smac;
    logic [MAC_W-1:0]   dmac;
    logic [PORT_W-1:0]  rng_end;
    logic [PORT_W-1:0]  rng_begin;
    logic [IDX_W-1:0]   idx;
  } header_t;

  typedef struct {
    action_e          act;
    logic [MAC_W-1:0] mac;
    logic [LEN_W-1:0] len;
    logic             last;
  } verdict_t;

  logic [1:0]       mode_q;
  logic [MAC_W-1:0] sniff_q, own_q, takeover_q;
  logic [3:0]       count_q;
  logic [PORT_W-1:0] lo_q [RANGES];
  logic [PORT_W-1:0] hi_q [RANGES];
  verdict_t         verdicts_q[$];
  int               fails = 0;

  assign fails_o = fails;

  function automatic bit port_listed(logic [PORT_W-1:0] p);
    int n;
    n = (count_q > RANGES) ? int'(RANGES) : int'(count_q);
    for (int i = 0; i < n; i++) begin
      if (p >= lo_q[i] && p <= hi_q[i]) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void expect_steering(header_t h);
    logic [LEN_W-1:0] len;
    bit               tcp, udp;
    verdict_t         v, swap;
    len = (h.ip_len > h.cap_len) ? h.cap_len : h.ip_len;
    tcp = (h.proto == PROTO_TCP);
    udp = (h.proto == PROTO_UDP);
    v.act = ACT_ATTACK;
    v.mac = '0;
    v.len = len;
    v.last = 1'b1;
    if (mode_q == MODE_STEER) begin
      // sniff rules take priority when both MACs match
      if (h.dmac == sniff_q) begin
        if ((tcp || udp) && !port_listed(h.dport)) begin
          v.act = ACT_DROP;
        end else if (tcp && h.rst_flag) begin
          swap = v;
          swap.act = ACT_FWD_RST;
          swap.mac = own_q;
          swap.last = 1'b0;
          verdicts_q.push_back(swap);
        end
      end else if (h.dmac == own_q) begin
        if ((tcp || udp) && port_listed(h.sport)) begin
          v.act = ACT_DROP;
        end else begin
          v.act = ACT_FWD;
          v.mac = h.smac;
        end
      end
    end
    verdicts_q.push_back(v);
  endfunction

  function automatic logic [APB_DATA_W-1:0] reg_value(reg_e r);
    case (r)
      REG_MODE:         return APB_DATA_W'(mode_q);
      REG_SNIFF_MAC:    return APB_DATA_W'(sniff_q);
      REG_OWN_MAC:      return APB_DATA_W'(own_q);
      REG_TAKEOVER_MAC: return APB_DATA_W'(takeover_q);
      REG_RANGE_COUNT:  return APB_DATA_W'(count_q);
      default:          return '0;
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    header_t                 h;
    verdict_t                v;
    logic [OUT_DATA_W-1:0]   d;
    reg_e                    r;
    if (!rst_ni) begin
      mode_q = '0;
      sniff_q = '0;
      own_q = '0;
      takeover_q = '0;
      count_q = '0;
      verdicts_q.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (verdicts_q.size() == 0) begin
          $error("result transfer with no verdict pending");
          fails++;
        end else begin
          v = verdicts_q.pop_front();
          d = out_data_i;
          if (d[1:0] !== v.act) begin
            $error("action: expected %0d, got %0d", v.act, d[1:0]);
            fails++;
          end
          if (d[49:2] !== v.mac) begin
            $error("forward_src_mac: expected %h, got %h", v.mac, d[49:2]);
            fails++;
          end
          if (d[65:50] !== v.len) begin
            $error("out_len: expected %0d, got %0d", v.len, d[65:50]);
            fails++;
          end
          if (d[OUT_DATA_W-1:66] !== '0) begin
            $error("pad: expected 0, got %h", d[OUT_DATA_W-1:66]);
            fails++;
          end
          if (out_last_i !== v.last) begin
            $error("last: expected %0d, got %0d", v.last, out_last_i);
            fails++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        h = header_t'(in_data_i);
        if (in_user_i == OP_WRITE) begin
          if (h.idx < RANGES) begin
            lo_q[h.idx] = h.rng_begin;
            hi_q[h.idx] = h.rng_end;
          end
        end else begin
          expect_steering(h);
        end
      end
      if (psel_i && penable_i && pready_i) begin
        r = reg_e'(paddr_i[APB_ADDR_W-1:3]);
        if (pwrite_i) begin
          case (r)
            REG_MODE:         mode_q = pwdata_i[1:0];
            REG_SNIFF_MAC:    sniff_q = pwdata_i[MAC_W-1:0];
            REG_OWN_MAC:      own_q = pwdata_i[MAC_W-1:0];
            REG_TAKEOVER_MAC: takeover_q = pwdata_i[MAC_W-1:0];
            REG_RANGE_COUNT:  count_q = pwdata_i[3:0];
            default: ;
          endcase
        end else if (prdata_i !== reg_value(r)) begin
          $error("prdata reg %0d: expected %h, got %h", r, reg_value(r), prdata_i);
          fails++;
        end
      end
      pending_o <= verdicts_q.size();
    end
  end

endmodule

>>> bench/takeover_packet_steering_classifier_tb.sv
`timescale 1ns / 1ps
// Top of the takeover packet steering classifier bench: clock, reset, stimulus and
// verdict. Prediction and checking live in tpsc_checker. Depends on tpsc_pkg.
module takeover_packet_steering_classifier_tb;
  import tpsc_pkg::*;

  localparam int unsigned RANGES = 8;
  // Longest legal stretch without any transfer is the one long sink hold.
  localparam int          LIMIT  = 3000;
  // Quiet cycles after the last result before touching registers: a range write
  // can still be in flight, and a classify must finish its walk of the cell chain.
  localparam int          DRAIN  = RANGES + 4;
  localparam int          PHASES = 12;
  localparam int          PHASE_ITEMS = 127;

  localparam logic [1:0] MODE_ORIGINAL = 2'd0;
  localparam logic [1:0] MODE_SAME     = 2'd1;
  localparam logic [1:0] MODE_THREE    = 2'd3;
  localparam logic [PROTO_W-1:0] PROTO_ICMP = 8'd1;
  localparam logic [PROTO_W-1:0] PROTO_ANY  = 8'hFF;

  localparam logic [MAC_W-1:0] SNIFF_A = 48'h025A_0000_005A;
  localparam logic [MAC_W-1:0] OWN_A   = 48'h0200_0000_0001;
  localparam logic [MAC_W-1:0] TAKE_A  = 48'h027E_0000_007E;
  localparam logic [MAC_W-1:0] PEER_A  = 48'h0A0B_0C0D_0E0F;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  psel, penable, pwrite, pready;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata, prdata;
  int                    pending, fails;

  // Per-phase switches: a quiet side takes no random idles.
  bit tx_quiet, rx_quiet;

  // Our own copy of the range table and MACs, only to aim stimulus at boundaries.
  logic [PORT_W-1:0] lo_t [RANGES];
  logic [PORT_W-1:0] hi_t [RANGES];
  logic [MAC_W-1:0]  sniff_t, own_t;

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  takeover_packet_steering_classifier #(.RANGES(RANGES)) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tlast_o  (m_axis_tlast),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  tpsc_checker #(.RANGES(RANGES)) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_i  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .out_valid_i (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_i  (m_axis_tdata),
    .out_last_i  (m_axis_tlast),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .prdata_i    (prdata),
    .pready_i    (pready),
    .pending_o   (pending),
    .fails_o     (fails)
  );

  // Idle length: mostly none, some short, a few long.
  function automatic int pause_len(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [MAC_W-1:0] any_mac();
    return {16'($urandom), 32'($urandom)};
  endfunction

  // Fill for fields the item's opcode ignores: they still toggle.
  function automatic logic [34:0] write_noise();
    return {3'($urandom), 32'($urandom)};
  endfunction

  function automatic logic [168:0] header_noise();
    return {9'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom};
  endfunction

  // Port near a stored range boundary most of the time, else extremes or random.
  function automatic logic [PORT_W-1:0] pick_port();
    int r, j;
    r = $urandom_range(0, 9);
    j = $urandom_range(0, RANGES - 1);
    if (r < 2) return lo_t[j];
    if (r < 4) return hi_t[j];
    if (r == 4) return lo_t[j] - 16'd1;
    if (r == 5) return hi_t[j] + 16'd1;
    if (r == 6) return ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
    return 16'($urandom);
  endfunction

  // One input transfer. tvalid stays up when no idle follows, so the next call
  // raises it again without a drop in between.
  task automatic send(opcode_e op, logic [IN_DATA_W-1:0] d);
    int g;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    g = pause_len(tx_quiet);
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic write_range(logic [IDX_W-1:0] idx, logic [PORT_W-1:0] b,
                             logic [PORT_W-1:0] e);
    lo_t[idx] = b;
    hi_t[idx] = e;
    send(OP_WRITE, {4'b0, header_noise(), e, b, idx});
  endtask

  task automatic packet(logic [MAC_W-1:0] dmac, logic [MAC_W-1:0] smac,
                        logic [PROTO_W-1:0] proto, logic [PORT_W-1:0] sport,
                        logic [PORT_W-1:0] dport, logic rst, logic [LEN_W-1:0] len,
                        logic [LEN_W-1:0] cap);
    send(OP_CLASSIFY, {4'b0, cap, len, rst, dport, sport, proto, smac, dmac,
                       write_noise()});
  endtask

  // Drop tvalid, wait for every predicted result, then let the pipe go quiet.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  // Setup then access; psel stays up between back-to-back accesses.
  task automatic apb_access(bit wr, reg_e r, logic [APB_DATA_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {r, 3'b000};
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
  endtask

  // Full register set per phase, then read back (checked in the scoreboard).
  task automatic configure(logic [1:0] m, logic [MAC_W-1:0] s, logic [MAC_W-1:0] o,
                           logic [MAC_W-1:0] t, logic [3:0] n);
    wait_idle();
    sniff_t = s;
    own_t   = o;
    apb_access(1'b1, REG_MODE, APB_DATA_W'(m));
    apb_access(1'b1, REG_SNIFF_MAC, APB_DATA_W'(s));
    apb_access(1'b1, REG_OWN_MAC, APB_DATA_W'(o));
    apb_access(1'b1, REG_TAKEOVER_MAC, APB_DATA_W'(t));
    apb_access(1'b1, REG_RANGE_COUNT, APB_DATA_W'(n));
    apb_access(1'b0, REG_MODE, '0);
    apb_access(1'b0, REG_SNIFF_MAC, '0);
    apb_access(1'b0, REG_OWN_MAC, '0);
    apb_access(1'b0, REG_TAKEOVER_MAC, '0);
    apb_access(1'b0, REG_RANGE_COUNT, '0);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic rand_range_write();
    logic [PORT_W-1:0] b, e;
    int                r;
    b = 16'($urandom);
    r = $urandom_range(0, 99);
    if (r < 70) begin
      // narrow range, saturating at the top port
      e = (b > 16'd65335) ? 16'hFFFF : b + 16'($urandom_range(0, 200));
    end else if (r < 85) begin
      // empty: begin above end
      if (b == 16'd0) b = 16'd1;
      e = b - 16'($urandom_range(1, 1 + int'(b) - 1));
    end else begin
      e = 16'($urandom);
    end
    write_range(3'($urandom), b, e);
  endtask

  task automatic rand_packet();
    logic [MAC_W-1:0]   dmac;
    logic [PROTO_W-1:0] proto;
    logic [LEN_W-1:0]   len, cap;
    int                 r;
    r = $urandom_range(0, 99);
    if (r < 40) dmac = sniff_t;
    else if (r < 70) dmac = own_t;
    else if (r < 90) dmac = any_mac();
    else dmac = sniff_t ^ (48'd1 << $urandom_range(0, MAC_W - 1));
    r = $urandom_range(0, 99);
    if (r < 45) proto = PROTO_TCP;
    else if (r < 80) proto = PROTO_UDP;
    else proto = 8'($urandom);
    len = 16'($urandom);
    r = $urandom_range(0, 99);
    if (r < 15) cap = len;
    else if (r < 25) cap = 16'($urandom_range(0, 64));
    else cap = 16'($urandom);
    packet(dmac, any_mac(), proto, pick_port(), pick_port(), 1'($urandom), len, cap);
  endtask

  // Mostly headers; one in ten transfers rewrites a range entry mid-stream.
  task automatic run_phase(int items, int pause_at);
    for (int i = 0; i < items; i++) begin
      if (i == pause_at) wait_idle();
      if ($urandom_range(0, 9) == 0) rand_range_write();
      else rand_packet();
    end
  endtask

  // Result sink: random stalls, plus one long hold once traffic is flowing so the
  // pipe backs up into the input side.
  initial begin : sink
    int g, taken;
    bit held;
    taken = 0;
    held  = 1'b0;
    m_axis_tready <= 1'b0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (!held && taken >= 150) begin
        held = 1'b1;
        g = 500;
      end else begin
        g = pause_len(rx_quiet);
      end
      if (g > 0) begin
        m_axis_tready <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      taken++;
    end
  end

  // Watchdog: ends the run as a fail once transfers of every kind stop for good.
  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
        stuck = 0;
      else
        stuck++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    logic [1:0]       m;
    logic [MAC_W-1:0] s;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= OP_CLASSIFY;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    tx_quiet      = 1'b0;
    rx_quiet      = 1'b0;
    sniff_t       = '0;
    own_t         = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fill every entry before any takeover lookup can read one. Entry 3 is empty,
    // entry 5 spans every port.
    write_range(3'd0, 16'd0, 16'd0);
    write_range(3'd1, 16'hFFFF, 16'hFFFF);
    write_range(3'd2, 16'd1000, 16'd2000);
    write_range(3'd3, 16'd5000, 16'd4000);
    write_range(3'd4, 16'd80, 16'd80);
    write_range(3'd5, 16'd0, 16'hFFFF);
    write_range(3'd6, 16'd30000, 16'd30010);
    write_range(3'd7, 16'd443, 16'd443);
    // Reset mode routes everything to the attack path, even a reset for sniff MAC 0.
    packet('0, PEER_A, PROTO_TCP, 16'd80, 16'd1500, 1'b1, 16'hFFFF, 16'hFFFF);

    // Takeover with entries 0..4 in use.
    configure(MODE_STEER, SNIFF_A, OWN_A, TAKE_A, 4'd5);
    packet(SNIFF_A, PEER_A, PROTO_TCP, 16'd1234, 16'd1500, 1'b1, 16'd100, 16'd60);
    packet(SNIFF_A, PEER_A, PROTO_TCP, 16'd1234, 16'd3000, 1'b0, 16'd60, 16'd100);
    packet(SNIFF_A, PEER_A, PROTO_UDP, 16'd53, 16'd0, 1'b0, 16'd28, 16'd28);
    packet(SNIFF_A, PEER_A, PROTO_UDP, 16'd53, 16'hFFFF, 1'b0, 16'd40, 16'd1500);
    packet(SNIFF_A, PEER_A, PROTO_TCP, 16'd22, 16'd4500, 1'b1, 16'd40, 16'd40);
    packet(SNIFF_A, PEER_A, PROTO_ICMP, 16'd0, 16'd3000, 1'b1, 16'd84, 16'd84);
    packet(SNIFF_A, PEER_A, PROTO_UDP, 16'd53, 16'd80, 1'b1, 16'd76, 16'd76);
    packet(OWN_A, PEER_A, PROTO_TCP, 16'd80, 16'd5555, 1'b0, 16'd52, 16'd52);
    packet(OWN_A, PEER_A, PROTO_UDP, 16'd81, 16'd5555, 1'b0, 16'd52, 16'd30);
    packet(OWN_A, PEER_A, PROTO_ANY, 16'd80, 16'd80, 1'b1, 16'd20, 16'd20);
    packet(SNIFF_A ^ 48'd1, PEER_A, PROTO_TCP, 16'd80, 16'd80, 1'b1, 16'd0, 16'hFFFF);
    packet(SNIFF_A, OWN_A, PROTO_TCP, 16'hFFFF, 16'd2000, 1'b1, 16'hFFFF, 16'd0);

    // Sniff and own MAC equal, range count beyond the table size.
    configure(MODE_STEER, SNIFF_A, SNIFF_A, TAKE_A, 4'd15);
    packet(SNIFF_A, PEER_A, PROTO_TCP, 16'd80, 16'd443, 1'b0, 16'd90, 16'd90);
    packet(SNIFF_A, PEER_A, PROTO_TCP, 16'd80, 16'd12345, 1'b1, 16'd90, 16'd90);

    // The unnamed fourth mode and route-same both fall through to the attack path.
    configure(MODE_THREE, SNIFF_A, OWN_A, TAKE_A, 4'd8);
    packet(SNIFF_A, PEER_A, PROTO_TCP, 16'd80, 16'd3000, 1'b1, 16'd60, 16'd60);
    configure(MODE_SAME, SNIFF_A, OWN_A, TAKE_A, 4'd8);
    packet(OWN_A, PEER_A, PROTO_TCP, 16'd99, 16'd99, 1'b0, 16'd60, 16'd60);

    // No ranges in use: every sniff port misses, no own port hits.
    configure(MODE_STEER, SNIFF_A, OWN_A, TAKE_A, 4'd0);
    packet(SNIFF_A, PEER_A, PROTO_UDP, 16'd53, 16'd0, 1'b0, 16'd60, 16'd60);
    packet(OWN_A, PEER_A, PROTO_TCP, 16'd80, 16'd80, 1'b0, 16'd60, 16'd60);
    configure(MODE_ORIGINAL, SNIFF_A, OWN_A, TAKE_A, 4'd0);

    // Random phases: mostly takeover mode, where the range table matters.
    for (int p = 0; p < PHASES; p++) begin
      if (p == 0) begin
        configure(MODE_STEER, '1, '0, '1, 4'd15);
      end else begin
        m = ($urandom_range(0, 99) < 70) ? MODE_STEER : 2'($urandom);
        s = any_mac();
        configure(m, s, ($urandom_range(0, 9) == 0) ? s : any_mac(), any_mac(),
                  (p == 1) ? 4'd8 : 4'($urandom));
      end
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      // One phase stops mid-way until every result is back.
      run_phase(PHASE_ITEMS, (p == 3) ? PHASE_ITEMS / 2 : -1);
    end

    wait_idle();
    if (fails == 0 && pending == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
